// ===== rtl/box_blur_3x3_rgb_top_defines.svh =====
// Assertion macros for the box blur block.
// Each macro expects clk_i and rst_ni to be visible at the place of use.
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BB3_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box blur check failed");
`define BB3_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box blur check failed");
`else
`define BB3_ASSERT_SAME(name, ante, cons)
`define BB3_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

  localparam int ChanW     = 8;
  localparam int ColOutW   = 11;
  localparam int RowOutW   = 12;
  localparam int PixW      = 3 * ChanW;
  localparam int CfgDataW  = 13;
  localparam int FrameWidthW  = 12;
  localparam int FrameHeightW = 13;

  localparam int FrameWidthReset  = 640;
  localparam int FrameHeightReset = 480;

  localparam int QueueDepth = 4;

  // x / 9 for x up to 9 * 255 is (x * 7282) >> 16.
  localparam logic [12:0] Div9Recip = 13'd7282;
  localparam int          Div9Shift = 16;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Sum of three pixels of one column, per channel.
  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } col_sum_t;

  // Sum of nine pixels, per channel.
  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } box_sum_t;

  typedef struct packed {
    col_sum_t             sum_left;
    col_sum_t             sum_mid;
    col_sum_t             sum_right;
    pixel_t               pix;
    logic [ColOutW-1:0]   col;
    logic [RowOutW-1:0]   row;
    logic                 interior;
    logic                 border;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_beat_t;

  function automatic col_sum_t col_sum(pixel_t a, pixel_t b, pixel_t c);
    col_sum_t s;
    s.red   = 10'(a.red)   + 10'(b.red)   + 10'(c.red);
    s.green = 10'(a.green) + 10'(b.green) + 10'(c.green);
    s.blue  = 10'(a.blue)  + 10'(b.blue)  + 10'(c.blue);
    return s;
  endfunction

  function automatic box_sum_t box_sum(col_sum_t a, col_sum_t b, col_sum_t c);
    box_sum_t s;
    s.red   = 12'(a.red)   + 12'(b.red)   + 12'(c.red);
    s.green = 12'(a.green) + 12'(b.green) + 12'(c.green);
    s.blue  = 12'(a.blue)  + 12'(b.blue)  + 12'(c.blue);
    return s;
  endfunction

  function automatic logic [ChanW-1:0] div9(logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(Div9Recip);
    return prod[Div9Shift +: ChanW];
  endfunction

endpackage

// ===== rtl/bb3_ram.sv =====
module bb3_ram #(
  parameter int Width = 48,
  parameter int Depth = 2048,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/bb3_front.sv =====
module bb3_front import bb3_pkg::*; #(
  parameter int MaxWidth  = 2048,
  parameter int MaxHeight = 4096,
  localparam int WidthW  = $clog2(MaxWidth + 1),
  localparam int HeightW = $clog2(MaxHeight + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WidthW-1:0]  width_i,
  input  logic [HeightW-1:0] height_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pixel_t             in_pix_i,
  output queue_beat_t        push_o,
  input  logic               full_i
);

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic               s1_valid_q;
  pixel_t             s1_pix_q;
  logic [ColW-1:0]    s1_idx_q;
  logic [ColOutW-1:0] s1_col_q;
  logic [RowOutW-1:0] s1_row_q;
  logic               s1_interior_q;
  logic               s1_border_q;
  logic               fwd_q;
  logic [2*PixW-1:0]  fwd_data_q;
  col_sum_t           win_near_q;
  col_sum_t           win_far_q;

  logic              accept;
  logic              s1_adv;
  logic              need_push;
  logic [ColW:0]     col_inc;
  logic [RowW:0]     row_inc;
  logic [ColW:0]     width_ext;
  logic [RowW:0]     height_ext;
  logic              col_last, row_last, col_in, row_in;
  logic              border, interior;
  logic [2*PixW-1:0] ram_rdata;
  logic [2*PixW-1:0] lines;
  logic [2*PixW-1:0] wdata;
  pixel_t            line_older, line_newer;
  col_sum_t          cur_sum;

  // Classification of the pixel at the current counters, and the counters' next values.
  always_comb begin
    width_ext  = (ColW + 1)'(width_i);
    height_ext = (RowW + 1)'(height_i);
    col_inc    = {1'b0, col_q} + (ColW + 1)'(1);
    row_inc    = {1'b0, row_q} + (RowW + 1)'(1);
    col_last   = col_inc >= width_ext;
    row_last   = row_inc >= height_ext;
    col_in     = {1'b0, col_q} < width_ext;
    row_in     = {1'b0, row_q} < height_ext;
    border     = (col_q == '0) || (row_q == '0) || col_last || row_last;
    interior   = (col_q >= ColW'(2)) && (row_q >= RowW'(2)) && col_in && row_in;
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_q;
    end
  end

  assign need_push  = s1_interior_q || s1_border_q;
  assign s1_adv     = s1_valid_q && (!need_push || !full_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign lines      = fwd_q ? fwd_data_q : ram_rdata;
  assign line_older = lines[2*PixW-1:PixW];
  assign line_newer = lines[PixW-1:0];
  assign cur_sum    = col_sum(line_older, line_newer, s1_pix_q);
  assign wdata      = {line_newer, s1_pix_q};

  // Both line buffers share one word: {older, newer}.
  bb3_ram #(
    .Width (2 * PixW),
    .Depth (MaxWidth)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    push_o.valid              = s1_valid_q && need_push && !full_i;
    push_o.entry.sum_left     = win_far_q;
    push_o.entry.sum_mid      = win_near_q;
    push_o.entry.sum_right    = cur_sum;
    push_o.entry.pix          = s1_pix_q;
    push_o.entry.col          = s1_col_q;
    push_o.entry.row          = s1_row_q;
    push_o.entry.interior     = s1_interior_q;
    push_o.entry.border       = s1_border_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_near_q <= '0;
      win_far_q  <= '0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        // The word read now misses a write to the same entry in this cycle.
        fwd_q <= s1_adv && (s1_idx_q == col_q);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_far_q  <= win_near_q;
        win_near_q <= cur_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= in_pix_i;
      s1_idx_q      <= col_q;
      s1_col_q      <= ColOutW'(col_q);
      s1_row_q      <= RowOutW'(row_q);
      s1_interior_q <= interior;
      s1_border_q   <= border;
      fwd_data_q    <= wdata;
    end
  end

endmodule

// ===== rtl/bb3_fifo.sv =====
module bb3_fifo import bb3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_beat_t push_i,
  output logic        full_o,
  output queue_beat_t head_o,
  input  logic        pop_i
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t          store_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o       = count_q == CntW'(QueueDepth);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = store_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !push_i.valid) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      store_q[wptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== rtl/bb3_back.sv =====
module bb3_back import bb3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_beat_t        head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ColOutW-1:0] out_col_o,
  output logic [RowOutW-1:0] out_row_o,
  output pixel_t             out_pix_o,
  output logic               last_of_run_o
);

  logic               b1_valid_q;
  box_sum_t           b1_sum_q;
  pixel_t             b1_pix_q;
  logic [ColOutW-1:0] b1_col_q;
  logic [RowOutW-1:0] b1_row_q;
  logic               b1_interior_q;
  logic               b1_border_q;

  logic               out_valid_q;
  logic [ColOutW-1:0] out_col_q;
  logic [RowOutW-1:0] out_row_q;
  pixel_t             out_pix_q;
  logic               out_last_q;

  logic   load;
  logic   b1_done;
  pixel_t blurred;

  assign load    = b1_valid_q && (!out_valid_q || !out_stall_i);
  assign b1_done = load && (!b1_interior_q || !b1_border_q);
  assign pop_o   = head_i.valid && (!b1_valid_q || b1_done);

  always_comb begin
    blurred.red   = div9(b1_sum_q.red);
    blurred.green = div9(b1_sum_q.green);
    blurred.blue  = div9(b1_sum_q.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q    <= 1'b0;
      b1_interior_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        b1_valid_q    <= 1'b1;
        b1_interior_q <= head_i.entry.interior;
      end else begin
        if (b1_done) begin
          b1_valid_q <= 1'b0;
        end
        // The blurred result goes out first; the border copy stays behind.
        if (load) begin
          b1_interior_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_sum_q    <= box_sum(head_i.entry.sum_left, head_i.entry.sum_mid,
                             head_i.entry.sum_right);
      b1_pix_q    <= head_i.entry.pix;
      b1_col_q    <= head_i.entry.col;
      b1_row_q    <= head_i.entry.row;
      b1_border_q <= head_i.entry.border;
    end
    if (load) begin
      if (b1_interior_q) begin
        out_col_q  <= b1_col_q - ColOutW'(1);
        out_row_q  <= b1_row_q - RowOutW'(1);
        out_pix_q  <= blurred;
        out_last_q <= !b1_border_q;
      end else begin
        out_col_q  <= b1_col_q;
        out_row_q  <= b1_row_q;
        out_pix_q  <= b1_pix_q;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_col_o     = out_col_q;
  assign out_row_o     = out_row_q;
  assign out_pix_o     = out_pix_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== rtl/box_blur_3x3_rgb_top.sv =====
// Streaming 3x3 box blur over RGB pixels in raster order.
// A result passes the front-end register, the queue, the back-end register and the output register.
// Throughput: one beat per cycle while the queue has room, but a beat with two results
// (right edge from row two on, bottom row from column two on) holds the back end until
// both have gone out, so once the queue fills the bottom row stalls the input.
// Asynchronous active-low reset clears counters, pipeline and queue and sets 640x480.
`include "box_blur_3x3_rgb_top_defines.svh"

module box_blur_3x3_rgb_top import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ChanW-1:0]    in_red_i,
  input  logic [ChanW-1:0]    in_green_i,
  input  logic [ChanW-1:0]    in_blue_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ColOutW-1:0]  out_col_o,
  output logic [RowOutW-1:0]  out_row_o,
  output logic [ChanW-1:0]    out_red_o,
  output logic [ChanW-1:0]    out_green_o,
  output logic [ChanW-1:0]    out_blue_o,
  output logic                last_of_run_o
);

  localparam int WidthW  = $clog2(MAX_WIDTH + 1);
  localparam int HeightW = $clog2(MAX_HEIGHT + 1);
  localparam int ResetWidth  = (FrameWidthReset > MAX_WIDTH) ? MAX_WIDTH : FrameWidthReset;
  localparam int ResetHeight =
    (FrameHeightReset > MAX_HEIGHT) ? MAX_HEIGHT : FrameHeightReset;

  // The frame size is kept in its effective form: zero reads as one and values
  // above the supported maximum saturate. The conversion happens on the write,
  // so the pixel path only ever compares against a legal size.
  logic [WidthW-1:0]       frame_width_q, frame_width_d;
  logic [HeightW-1:0]      frame_height_q, frame_height_d;
  logic [FrameWidthW-1:0]  wr_width;
  logic [FrameHeightW-1:0] wr_height;

  always_comb begin
    wr_width       = cfg_wdata_i[FrameWidthW-1:0];
    wr_height      = cfg_wdata_i[FrameHeightW-1:0];
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          if (wr_width == '0) begin
            frame_width_d = WidthW'(1);
          end else if (32'(wr_width) > MAX_WIDTH) begin
            frame_width_d = WidthW'(MAX_WIDTH);
          end else begin
            frame_width_d = WidthW'(wr_width);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (wr_height == '0) begin
            frame_height_d = HeightW'(1);
          end else if (32'(wr_height) > MAX_HEIGHT) begin
            frame_height_d = HeightW'(MAX_HEIGHT);
          end else begin
            frame_height_d = HeightW'(wr_height);
          end
        end
        default: begin
          frame_width_d  = frame_width_q;
          frame_height_d = frame_height_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthW'(ResetWidth);
      frame_height_q <= HeightW'(ResetHeight);
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Front end: tracks the raster position, reads both line buffers, keeps the
  // window as column sums and decides whether the beat yields a blurred result,
  // a pass-through border result, both, or nothing. Beats that yield nothing
  // still update the line buffers and the window but never enter the queue.
  pixel_t      in_pix;
  queue_beat_t push;
  queue_beat_t head;
  logic        fifo_full;
  logic        pop;
  pixel_t      out_pix;

  assign in_pix.red   = in_red_i;
  assign in_pix.green = in_green_i;
  assign in_pix.blue  = in_blue_i;

  bb3_front #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (frame_width_q),
    .height_i   (frame_height_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix),
    .push_o     (push),
    .full_i     (fifo_full)
  );

  // A short queue decouples the two halves, so a right-edge pixel that produces
  // two results does not stall the input straight away.
  bb3_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (fifo_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back end: adds the three column sums, divides by nine and emits the
  // blurred result before the border copy when a beat yields both.
  bb3_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .out_pix_o     (out_pix),
    .last_of_run_o (last_of_run_o)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

  // The front end must never write into a full queue.
  `BB3_ASSERT_SAME(a_no_push_on_full, push.valid, !fifo_full)
  // The input only stalls because the queue has no room.
  `BB3_ASSERT_SAME(a_stall_only_on_full, in_stall_o, fifo_full)
  // A blurred result that is not the last of its beat is followed at once by
  // the border copy of the same beat.
  `BB3_ASSERT_NEXT(a_border_follows, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o && last_of_run_o)

endmodule
